### rtl/csgv_pkg.sv
// Shared constants and helper functions for the cube-sphere grid vertex block.
// Used by the top level and by the pipelined square root unit.
// No dependencies.
package csgv_pkg;

    // Field and register widths.
    localparam int COORD_W    = 8;
    localparam int GRID_W     = 9;
    localparam int RADIUS_W   = 20;
    localparam int INDEX_W    = 16;
    localparam int POS_W      = 22;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_UP_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_Z      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 3'd4;

    // Reset values of the configuration registers.
    localparam logic signed [1:0]     UP_X_RESET      = 2'sd0;
    localparam logic signed [1:0]     UP_Y_RESET      = 2'sd0;
    localparam logic signed [1:0]     UP_Z_RESET      = 2'sd1;
    localparam logic [GRID_W-1:0]     GRID_SIZE_RESET = 9'd16;
    localparam logic [RADIUS_W-1:0]   RADIUS_RESET    = 20'd30000;

    // The vertex length is carried with this many fraction bits.
    localparam int LEN_FRAC = 28;

    // Radicand width of the square root pipeline; the root has half as many bits.
    localparam int SQRT_W = 64;

    // Clamp a two-bit code to the unit range: the code for -2 reads as -1.
    function automatic logic signed [1:0] sat_unit(input logic [1:0] code);
        logic signed [1:0] val;
        val = (code == 2'b10) ? 2'sb11 : $signed(code);
        return val;
    endfunction

    // One component of the second tangent axis: p*q - r*r, range -2 to 1.
    function automatic logic signed [2:0] cross_coef(input logic signed [1:0] p,
                                                     input logic signed [1:0] q,
                                                     input logic signed [1:0] r);
        logic signed [2:0] pe;
        logic signed [2:0] qe;
        logic signed [2:0] re;
        pe = 3'(p);
        qe = 3'(q);
        re = 3'(r);
        return pe * qe - re * re;
    endfunction

endpackage

### rtl/csgv_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes sharing one divisor.
// A side tag travels with each item. Stand-alone; no package needed.
// The caller guarantees that every quotient fits in QUO_W bits.
module csgv_div_pipe #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 10,
    parameter int QUO_W = 15,
    parameter int LANES = 2,
    parameter int TAG_W = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [LANES-1:0][NUM_W-1:0] in_num,
    input  logic [DEN_W-1:0]            in_den,
    input  logic [TAG_W-1:0]            in_tag,
    output logic                        out_valid,
    output logic [LANES-1:0][QUO_W-1:0] out_quo,
    output logic [TAG_W-1:0]            out_tag
);

    localparam int CMP_W = DEN_W + QUO_W;

    // Inputs of each stage.
    logic                        valid_in [QUO_W];
    logic [LANES-1:0][CMP_W-1:0] rem_in   [QUO_W];
    logic [LANES-1:0][QUO_W-1:0] quo_in   [QUO_W];
    logic [DEN_W-1:0]            den_in   [QUO_W];
    logic [TAG_W-1:0]            tag_in   [QUO_W];

    logic [LANES-1:0][CMP_W-1:0] rem_next [QUO_W-1];
    logic [LANES-1:0][QUO_W-1:0] quo_next [QUO_W];

    logic [QUO_W-1:0]            valid_reg;
    logic [LANES-1:0][CMP_W-1:0] rem_reg  [QUO_W-1];
    logic [LANES-1:0][QUO_W-1:0] quo_reg  [QUO_W];
    logic [DEN_W-1:0]            den_reg  [QUO_W-1];
    logic [TAG_W-1:0]            tag_reg  [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        localparam int SH = QUO_W - 1 - k;

        if (k == 0) begin : g_first
            assign valid_in[k] = in_valid;
            assign den_in[k]   = in_den;
            assign tag_in[k]   = in_tag;
            for (genvar l = 0; l < LANES; l++) begin : g_load
                assign rem_in[k][l] = CMP_W'(in_num[l]);
                assign quo_in[k][l] = '0;
            end
        end else begin : g_chain
            assign valid_in[k] = valid_reg[k-1];
            assign den_in[k]   = den_reg[k-1];
            assign tag_in[k]   = tag_reg[k-1];
            assign rem_in[k]   = rem_reg[k-1];
            assign quo_in[k]   = quo_reg[k-1];
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [CMP_W:0] diff;
            logic           fits;

            // One subtract decides the bit: no borrow means the shifted divisor fits.
            assign diff = {1'b0, rem_in[k][l]} - {1'b0, CMP_W'(den_in[k]) << SH};
            assign fits = ~diff[CMP_W];
            assign quo_next[k][l] = quo_in[k][l] | (QUO_W'(fits) << SH);
            if (k < QUO_W - 1) begin : g_rem
                assign rem_next[k][l] = fits ? diff[CMP_W-1:0] : rem_in[k][l];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_in[k];
            end
        end

        always_ff @(posedge clk)
        begin
            quo_reg[k] <= quo_next[k];
            tag_reg[k] <= tag_in[k];
        end

        if (k < QUO_W - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_in[k];
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign out_quo   = quo_reg[QUO_W-1];
    assign out_tag   = tag_reg[QUO_W-1];

endmodule

### rtl/csgv_sqrt_pipe.sv
// Pipelined integer square root, one result bit per stage, floor of the root.
// Depends on csgv_pkg for the radicand width. A side tag travels with each item.
module csgv_sqrt_pipe #(
    parameter int TAG_W = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic [csgv_pkg::SQRT_W-1:0]     in_rad,
    input  logic [TAG_W-1:0]                in_tag,
    output logic                            out_valid,
    output logic [csgv_pkg::SQRT_W/2-1:0]   out_root,
    output logic [TAG_W-1:0]                out_tag
);

    localparam int SW    = csgv_pkg::SQRT_W;
    localparam int STEPS = SW / 2;

    logic          valid_in [STEPS];
    logic [SW-1:0] rad_in   [STEPS];
    logic [SW-1:0] res_in   [STEPS];
    logic [TAG_W-1:0] tag_in [STEPS];

    logic [SW-1:0] rad_next [STEPS-1];
    logic [SW-1:0] res_next [STEPS];

    logic [STEPS-1:0] valid_reg;
    logic [SW-1:0]    rad_reg [STEPS-1];
    logic [SW-1:0]    res_reg [STEPS];
    logic [TAG_W-1:0] tag_reg [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_stage
        localparam logic [SW-1:0] BIT = SW'(1) << (SW - 2 - 2 * k);

        logic [SW-1:0] trial;
        logic [SW:0]   diff;
        logic          fits;

        if (k == 0) begin : g_first
            assign valid_in[k] = in_valid;
            assign rad_in[k]   = in_rad;
            assign res_in[k]   = '0;
            assign tag_in[k]   = in_tag;
        end else begin : g_chain
            assign valid_in[k] = valid_reg[k-1];
            assign rad_in[k]   = rad_reg[k-1];
            assign res_in[k]   = res_reg[k-1];
            assign tag_in[k]   = tag_reg[k-1];
        end

        assign trial = res_in[k] + BIT;
        assign diff  = {1'b0, rad_in[k]} - {1'b0, trial};
        assign fits  = ~diff[SW];
        assign res_next[k] = fits ? ((res_in[k] >> 1) + BIT) : (res_in[k] >> 1);

        if (k < STEPS - 1) begin : g_rad
            assign rad_next[k] = fits ? diff[SW-1:0] : rad_in[k];
            always_ff @(posedge clk)
            begin
                rad_reg[k] <= rad_next[k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_in[k];
            end
        end

        always_ff @(posedge clk)
        begin
            res_reg[k] <= res_next[k];
            tag_reg[k] <= tag_in[k];
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign out_root  = res_reg[STEPS-1][STEPS-1:0];
    assign out_tag   = tag_reg[STEPS-1];

endmodule

### rtl/cube_sphere_grid_vertex.sv
// Top level of the cube-sphere grid vertex generator: config registers and the vertex pipeline.
// Depends on csgv_pkg, csgv_div_pipe and csgv_sqrt_pipe.
//
//   Channel   Signals                                    Transfer
//   input     start, busy, grid_x, grid_y                start high while busy low
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid and cfg_ready high
//   result    done, vertex_index, pos_*, has_quad, tri_* done high for one cycle
//
// One vertex enters per cycle and busy stays low; between transfer and result lie the stage
// registers, the tangent divider (one stage per quotient bit), the 32-stage square root and
// the 22-stage normalizing divider.
// Reset clears the config registers to their defaults and empties the pipeline.
// The receiver cannot stall, so the pipeline never holds.
module cube_sphere_grid_vertex #(
    parameter int MAX_GRID  = 256,
    parameter int FRAC_BITS = 14
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [csgv_pkg::COORD_W-1:0]           grid_x,
    input  logic [csgv_pkg::COORD_W-1:0]           grid_y,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [csgv_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [csgv_pkg::CFG_DATA_W-1:0]        cfg_data,
    output logic                                   done,
    output logic [csgv_pkg::INDEX_W-1:0]           vertex_index,
    output logic signed [csgv_pkg::POS_W-1:0]      pos_x,
    output logic signed [csgv_pkg::POS_W-1:0]      pos_y,
    output logic signed [csgv_pkg::POS_W-1:0]      pos_z,
    output logic                                   has_quad,
    output logic [csgv_pkg::INDEX_W-1:0]           tri_idx_0,
    output logic [csgv_pkg::INDEX_W-1:0]           tri_idx_1,
    output logic [csgv_pkg::INDEX_W-1:0]           tri_idx_2,
    output logic [csgv_pkg::INDEX_W-1:0]           tri_idx_3,
    output logic [csgv_pkg::INDEX_W-1:0]           tri_idx_4,
    output logic [csgv_pkg::INDEX_W-1:0]           tri_idx_5
);

    localparam int COORD_W  = csgv_pkg::COORD_W;
    localparam int GRID_W   = csgv_pkg::GRID_W;
    localparam int RADIUS_W = csgv_pkg::RADIUS_W;
    localparam int INDEX_W  = csgv_pkg::INDEX_W;
    localparam int POS_W    = csgv_pkg::POS_W;
    localparam int SQRT_W   = csgv_pkg::SQRT_W;
    localparam int ROOT_W   = SQRT_W / 2;

    localparam int NS      = csgv_pkg::LEN_FRAC - FRAC_BITS;
    localparam int TWO_R_W = RADIUS_W + 1;
    // Tangent coordinates: magnitude up to 2^FRAC_BITS.
    localparam int QUO1_W  = FRAC_BITS + 1;
    localparam int DEN1_W  = GRID_W + 1;
    localparam int NUM1_W  = FRAC_BITS + GRID_W + 1;
    localparam int T_W     = FRAC_BITS + 2;
    // Cube point components: magnitude up to 4 * 2^FRAC_BITS.
    localparam int P_W     = FRAC_BITS + 4;
    localparam int MAG_W   = FRAC_BITS + 3;
    localparam int SQ_W    = 2 * P_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int PROD_W  = MAG_W + TWO_R_W;
    localparam int NUM2_W  = PROD_W + NS + 1;
    localparam int DEN2_W  = ROOT_W + 1;
    localparam int QUO2_W  = POS_W;

    typedef struct packed {
        logic [INDEX_W-1:0] idx;
        logic               quad;
        logic [GRID_W-1:0]  n;
    } vtx_info_t;

    typedef struct packed {
        vtx_info_t info;
        logic      neg_x;
        logic      neg_y;
    } tan_tag_t;

    typedef struct packed {
        vtx_info_t               info;
        logic [2:0]              neg;
        logic [2:0][MAG_W-1:0]   mag;
    } root_tag_t;

    typedef struct packed {
        vtx_info_t  info;
        logic [2:0] neg;
        logic       zero;
    } norm_tag_t;

    // ---------------------------------------------------------------- config registers
    logic signed [1:0]   up_x_reg, up_x_next;
    logic signed [1:0]   up_y_reg, up_y_next;
    logic signed [1:0]   up_z_reg, up_z_next;
    logic [GRID_W-1:0]   grid_size_reg, grid_size_next;
    logic [RADIUS_W-1:0] radius_reg, radius_next;

    assign cfg_ready = 1'b1;
    // Every stage advances each cycle, so a new vertex is always welcome.
    assign busy = 1'b0;

    always_comb
    begin
        up_x_next      = up_x_reg;
        up_y_next      = up_y_reg;
        up_z_next      = up_z_reg;
        grid_size_next = grid_size_reg;
        radius_next    = radius_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                csgv_pkg::CFG_UP_X:      up_x_next = csgv_pkg::sat_unit(cfg_data[1:0]);
                csgv_pkg::CFG_UP_Y:      up_y_next = csgv_pkg::sat_unit(cfg_data[1:0]);
                csgv_pkg::CFG_UP_Z:      up_z_next = csgv_pkg::sat_unit(cfg_data[1:0]);
                csgv_pkg::CFG_GRID_SIZE: grid_size_next = cfg_data[GRID_W-1:0];
                csgv_pkg::CFG_RADIUS:    radius_next = cfg_data[RADIUS_W-1:0];
                default:                 ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_x_reg      <= csgv_pkg::UP_X_RESET;
            up_y_reg      <= csgv_pkg::UP_Y_RESET;
            up_z_reg      <= csgv_pkg::UP_Z_RESET;
            grid_size_reg <= csgv_pkg::GRID_SIZE_RESET;
            radius_reg    <= csgv_pkg::RADIUS_RESET;
        end
        else
        begin
            up_x_reg      <= up_x_next;
            up_y_reg      <= up_y_next;
            up_z_reg      <= up_z_next;
            grid_size_reg <= grid_size_next;
            radius_reg    <= radius_next;
        end
    end

    logic [TWO_R_W-1:0] two_r;
    assign two_r = {radius_reg, 1'b0};

    // Tangent axes: A = (up_y, up_z, up_x) and B = up x A.
    logic signed [1:0] up_v [3];
    logic signed [1:0] ax_v [3];
    logic signed [2:0] bx_v [3];

    assign up_v[0] = up_x_reg;
    assign up_v[1] = up_y_reg;
    assign up_v[2] = up_z_reg;
    assign ax_v[0] = up_y_reg;
    assign ax_v[1] = up_z_reg;
    assign ax_v[2] = up_x_reg;
    assign bx_v[0] = csgv_pkg::cross_coef(up_y_reg, up_x_reg, up_z_reg);
    assign bx_v[1] = csgv_pkg::cross_coef(up_z_reg, up_y_reg, up_x_reg);
    assign bx_v[2] = csgv_pkg::cross_coef(up_x_reg, up_z_reg, up_y_reg);

    // ---------------------------------------------------------------- stage 1: clamp
    logic              accept;
    logic [GRID_W-1:0] n_lim;
    logic [GRID_W-1:0] d_lim;
    logic [COORD_W-1:0] x_lim;
    logic [COORD_W-1:0] y_lim;

    assign accept = start && !busy;

    always_comb
    begin
        if (grid_size_reg < GRID_W'(2))
        begin
            n_lim = GRID_W'(2);
        end
        else if (int'(grid_size_reg) > MAX_GRID)
        begin
            n_lim = GRID_W'(MAX_GRID);
        end
        else
        begin
            n_lim = grid_size_reg;
        end
        d_lim = n_lim - GRID_W'(1);
        // A coordinate past the last column can only happen when d fits in a coordinate.
        x_lim = (GRID_W'(grid_x) > d_lim) ? d_lim[COORD_W-1:0] : grid_x;
        y_lim = (GRID_W'(grid_y) > d_lim) ? d_lim[COORD_W-1:0] : grid_y;
    end

    logic               v1_reg;
    logic [COORD_W-1:0] x1_reg;
    logic [COORD_W-1:0] y1_reg;
    logic [GRID_W-1:0]  n1_reg;
    logic [GRID_W-1:0]  d1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg <= x_lim;
        y1_reg <= y_lim;
        n1_reg <= n_lim;
        d1_reg <= d_lim;
    end

    // ---------------------------------------------------------------- stage 2: index, numerators
    logic [GRID_W+COORD_W-1:0] idx_wide;
    logic [GRID_W-1:0]         twice_x;
    logic [GRID_W-1:0]         twice_y;
    logic                      neg_x2;
    logic                      neg_y2;
    logic [GRID_W-1:0]         mag_x2;
    logic [GRID_W-1:0]         mag_y2;
    tan_tag_t                  tan_tag_next;
    logic [1:0][NUM1_W-1:0]    num1_next;

    always_comb
    begin
        idx_wide = (GRID_W+COORD_W)'(x1_reg)
                 + (GRID_W+COORD_W)'(y1_reg) * (GRID_W+COORD_W)'(n1_reg);
        twice_x  = {x1_reg, 1'b0};
        twice_y  = {y1_reg, 1'b0};
        neg_x2   = twice_x < d1_reg;
        neg_y2   = twice_y < d1_reg;
        mag_x2   = neg_x2 ? (d1_reg - twice_x) : (twice_x - d1_reg);
        mag_y2   = neg_y2 ? (d1_reg - twice_y) : (twice_y - d1_reg);
        // Round half away from zero: (2*|num| + d) / (2*d).
        num1_next[0] = (NUM1_W'(mag_x2) << (FRAC_BITS + 1)) + NUM1_W'(d1_reg);
        num1_next[1] = (NUM1_W'(mag_y2) << (FRAC_BITS + 1)) + NUM1_W'(d1_reg);
        tan_tag_next.info.idx  = idx_wide[INDEX_W-1:0];
        tan_tag_next.info.quad = (GRID_W'(x1_reg) < d1_reg) && (GRID_W'(y1_reg) < d1_reg);
        tan_tag_next.info.n    = n1_reg;
        tan_tag_next.neg_x     = neg_x2;
        tan_tag_next.neg_y     = neg_y2;
    end

    logic                   v2_reg;
    logic [1:0][NUM1_W-1:0] num1_reg;
    logic [DEN1_W-1:0]      den1_reg;
    tan_tag_t               tan_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        num1_reg    <= num1_next;
        den1_reg    <= {d1_reg, 1'b0};
        tan_tag_reg <= tan_tag_next;
    end

    logic                   tan_valid;
    logic [1:0][QUO1_W-1:0] tan_quo;
    tan_tag_t               tan_tag_out;

    csgv_div_pipe #(
        .NUM_W (NUM1_W),
        .DEN_W (DEN1_W),
        .QUO_W (QUO1_W),
        .LANES (2),
        .TAG_W ($bits(tan_tag_t))
    ) u_tan_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2_reg),
        .in_num    (num1_reg),
        .in_den    (den1_reg),
        .in_tag    (tan_tag_reg),
        .out_valid (tan_valid),
        .out_quo   (tan_quo),
        .out_tag   (tan_tag_out)
    );

    // ---------------------------------------------------------------- stage 3: cube point
    logic signed [T_W-1:0] tx;
    logic signed [T_W-1:0] ty;
    logic signed [P_W-1:0] p_next [3];

    always_comb
    begin
        tx = tan_tag_out.neg_x ? -T_W'(tan_quo[0]) : T_W'(tan_quo[0]);
        ty = tan_tag_out.neg_y ? -T_W'(tan_quo[1]) : T_W'(tan_quo[1]);
        for (int c = 0; c < 3; c++)
        begin
            p_next[c] = (P_W'(up_v[c]) <<< FRAC_BITS)
                      + P_W'(tx) * P_W'(ax_v[c])
                      + P_W'(ty) * P_W'(bx_v[c]);
        end
    end

    logic                  v3_reg;
    logic signed [P_W-1:0] p_reg [3];
    vtx_info_t             info3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= tan_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg     <= p_next;
        info3_reg <= tan_tag_out.info;
    end

    // ---------------------------------------------------------------- stage 4: squares
    logic signed [SQ_W-1:0] sq_next  [3];
    logic [MAG_W-1:0]       mag_next [3];
    logic signed [P_W-1:0]  p_abs    [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sq_next[c]  = SQ_W'(p_reg[c]) * SQ_W'(p_reg[c]);
            p_abs[c]    = p_reg[c][P_W-1] ? -p_reg[c] : p_reg[c];
            mag_next[c] = p_abs[c][MAG_W-1:0];
        end
    end

    logic                  v4_reg;
    logic [SQ_W-1:0]       sq_reg  [3];
    logic [MAG_W-1:0]      mag4_reg [3];
    logic [2:0]            neg4_reg;
    vtx_info_t             info4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            sq_reg[c]   <= sq_next[c];
            mag4_reg[c] <= mag_next[c];
            neg4_reg[c] <= p_reg[c][P_W-1];
        end
        info4_reg <= info3_reg;
    end

    // ---------------------------------------------------------------- stage 5: sum of squares
    logic [SUM_W-1:0]  sum_sq;
    logic [SQRT_W-1:0] rad_next;
    root_tag_t         root_tag_next;

    always_comb
    begin
        sum_sq   = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
        // Scale so that the root comes out with LEN_FRAC fraction bits.
        rad_next = SQRT_W'(sum_sq) << (2 * NS);
        root_tag_next.info = info4_reg;
        root_tag_next.neg  = neg4_reg;
        for (int c = 0; c < 3; c++)
        begin
            root_tag_next.mag[c] = mag4_reg[c];
        end
    end

    logic              v5_reg;
    logic [SQRT_W-1:0] rad_reg;
    root_tag_t         root_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else
        begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg      <= rad_next;
        root_tag_reg <= root_tag_next;
    end

    logic              root_valid;
    logic [ROOT_W-1:0] root;
    root_tag_t         root_tag_out;

    csgv_sqrt_pipe #(
        .TAG_W ($bits(root_tag_t))
    ) u_len_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .in_rad    (rad_reg),
        .in_tag    (root_tag_reg),
        .out_valid (root_valid),
        .out_root  (root),
        .out_tag   (root_tag_out)
    );

    // ---------------------------------------------------------------- stage 6: scale by 2r
    logic [PROD_W-1:0] prod_next [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            prod_next[c] = PROD_W'(root_tag_out.mag[c]) * PROD_W'(two_r);
        end
    end

    logic              v6_reg;
    logic [PROD_W-1:0] prod_reg [3];
    logic [ROOT_W-1:0] len6_reg;
    norm_tag_t         norm6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
        end
        else
        begin
            v6_reg <= root_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg       <= prod_next;
        len6_reg       <= root;
        norm6_reg.info <= root_tag_out.info;
        norm6_reg.neg  <= root_tag_out.neg;
        norm6_reg.zero <= (root == '0);
    end

    // ---------------------------------------------------------------- stage 7: numerators
    logic [2:0][NUM2_W-1:0] num2_next;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            // Round half away from zero: (2*num + len) / (2*len).
            num2_next[c] = (NUM2_W'(prod_reg[c]) << (NS + 1)) + NUM2_W'(len6_reg);
        end
    end

    logic                   v7_reg;
    logic [2:0][NUM2_W-1:0] num2_reg;
    logic [DEN2_W-1:0]      den2_reg;
    norm_tag_t              norm7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg <= 1'b0;
        end
        else
        begin
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        num2_reg  <= num2_next;
        den2_reg  <= {len6_reg, 1'b0};
        norm7_reg <= norm6_reg;
    end

    logic                   norm_valid;
    logic [2:0][QUO2_W-1:0] norm_quo;
    norm_tag_t              norm_tag_out;

    csgv_div_pipe #(
        .NUM_W (NUM2_W),
        .DEN_W (DEN2_W),
        .QUO_W (QUO2_W),
        .LANES (3),
        .TAG_W ($bits(norm_tag_t))
    ) u_norm_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v7_reg),
        .in_num    (num2_reg),
        .in_den    (den2_reg),
        .in_tag    (norm7_reg),
        .out_valid (norm_valid),
        .out_quo   (norm_quo),
        .out_tag   (norm_tag_out)
    );

    // ---------------------------------------------------------------- stage 8: result
    logic [QUO2_W-1:0]       sat_mag [3];
    logic signed [POS_W-1:0] pos_next [3];
    vtx_info_t               info_out;
    logic [INDEX_W-1:0]      n_ext;
    logic [INDEX_W-1:0]      tri_next [6];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sat_mag[c] = (norm_quo[c] > QUO2_W'(two_r)) ? QUO2_W'(two_r) : norm_quo[c];
            if (norm_tag_out.zero)
            begin
                pos_next[c] = '0;
            end
            else
            begin
                pos_next[c] = norm_tag_out.neg[c] ? -$signed(sat_mag[c]) : $signed(sat_mag[c]);
            end
        end
        info_out = norm_tag_out.info;
        n_ext    = INDEX_W'(info_out.n);
        for (int t = 0; t < 6; t++)
        begin
            tri_next[t] = '0;
        end
        if (info_out.quad)
        begin
            tri_next[0] = info_out.idx + n_ext;
            tri_next[1] = info_out.idx + n_ext + INDEX_W'(1);
            tri_next[2] = info_out.idx;
            tri_next[3] = info_out.idx + n_ext + INDEX_W'(1);
            tri_next[4] = info_out.idx + INDEX_W'(1);
            tri_next[5] = info_out.idx;
        end
    end

    logic                    done_reg;
    logic [INDEX_W-1:0]      idx_reg;
    logic                    quad_reg;
    logic signed [POS_W-1:0] pos_reg [3];
    logic [INDEX_W-1:0]      tri_reg [6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= norm_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= info_out.idx;
        quad_reg <= info_out.quad;
        pos_reg  <= pos_next;
        tri_reg  <= tri_next;
    end

    assign done         = done_reg;
    assign vertex_index = idx_reg;
    assign has_quad     = quad_reg;
    assign pos_x        = pos_reg[0];
    assign pos_y        = pos_reg[1];
    assign pos_z        = pos_reg[2];
    assign tri_idx_0    = tri_reg[0];
    assign tri_idx_1    = tri_reg[1];
    assign tri_idx_2    = tri_reg[2];
    assign tri_idx_3    = tri_reg[3];
    assign tri_idx_4    = tri_reg[4];
    assign tri_idx_5    = tri_reg[5];

endmodule

### bench/cube_sphere_grid_vertex_tb.sv
// Self-checking testbench for the cube-sphere grid vertex generator.
// Depends on csgv_pkg and cube_sphere_grid_vertex from the rtl folder.
module cube_sphere_grid_vertex_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC        = 14;
    localparam int GRID_MAX    = 256;
    localparam int SETTLE_CYC  = 120;
    localparam logic [csgv_pkg::CFG_IDX_W-1:0] CFG_UNUSED_5 = 3'd5;
    localparam logic [csgv_pkg::CFG_IDX_W-1:0] CFG_UNUSED_7 = 3'd7;

    typedef struct {
        logic [csgv_pkg::INDEX_W-1:0]       index;
        logic signed [csgv_pkg::POS_W-1:0]  px;
        logic signed [csgv_pkg::POS_W-1:0]  py;
        logic signed [csgv_pkg::POS_W-1:0]  pz;
        logic                               quad;
        logic [csgv_pkg::INDEX_W-1:0]       corner [6];
    } vertex_t;

    class vertex_scoreboard;
        vertex_t   pending_q [$];
        int        up [3];
        int        grid;
        int        rad;
        int        errors;
        int        checked;

        function new();
            up[0] = 0; up[1] = 0; up[2] = 1;
            grid = 16; rad = 30000;
            errors = 0; checked = 0;
        endfunction

        function void set_reg(logic [csgv_pkg::CFG_IDX_W-1:0] idx,
                              logic [csgv_pkg::CFG_DATA_W-1:0] data);
            int code;
            code = (data[1:0] == 2'b10) ? -1 : int'($signed(data[1:0]));
            case (idx)
                csgv_pkg::CFG_UP_X:      up[0] = code;
                csgv_pkg::CFG_UP_Y:      up[1] = code;
                csgv_pkg::CFG_UP_Z:      up[2] = code;
                csgv_pkg::CFG_GRID_SIZE: grid = int'(data[csgv_pkg::GRID_W-1:0]);
                csgv_pkg::CFG_RADIUS:    rad = int'(data[csgv_pkg::RADIUS_W-1:0]);
                default:                 ;
            endcase
        endfunction

        static function longint round_div(longint num, longint unsigned den);
            longint unsigned mag;
            longint unsigned q;
            mag = (num < 0) ? longint'(-num) : longint'(num);
            q = (2 * mag + den) / (2 * den);
            return (num < 0) ? -longint'(q) : longint'(q);
        endfunction

        static function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned root;
            longint unsigned bitv;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0)
            begin
                if (v >= root + bitv)
                begin
                    v -= root + bitv;
                    root = (root >> 1) + bitv;
                end
                else
                    root >>= 1;
                bitv >>= 2;
            end
            return root;
        endfunction

        function vertex_t predict_vertex(int gx, int gy);
            vertex_t         v;
            int              n;
            int              d;
            int              x;
            int              y;
            int              idx;
            longint          tx;
            longint          ty;
            longint          a [3];
            longint          b [3];
            longint          p [3];
            longint          comp;
            longint          two_r;
            longint unsigned sumsq;
            longint unsigned len;
            n = (grid < 2) ? 2 : (grid > GRID_MAX ? GRID_MAX : grid);
            d = n - 1;
            x = (gx > d) ? d : gx;
            y = (gy > d) ? d : gy;
            idx = x + y * n;
            tx = round_div(longint'(2 * x - d) * (64'sd1 <<< FRAC), d);
            ty = round_div(longint'(2 * y - d) * (64'sd1 <<< FRAC), d);
            a[0] = up[1]; a[1] = up[2]; a[2] = up[0];
            b[0] = up[1] * up[0] - up[2] * up[2];
            b[1] = up[2] * up[1] - up[0] * up[0];
            b[2] = up[0] * up[2] - up[1] * up[1];
            sumsq = 0;
            for (int c = 0; c < 3; c++)
            begin
                p[c] = longint'(up[c]) * (64'sd1 <<< FRAC) + tx * a[c] + ty * b[c];
                sumsq += longint'(p[c] * p[c]);
            end
            len = int_sqrt(sumsq << (2 * (csgv_pkg::LEN_FRAC - FRAC)));
            two_r = 2 * longint'(rad);
            for (int c = 0; c < 3; c++)
            begin
                comp = 0;
                if (len != 0)
                begin
                    comp = round_div(p[c] * two_r * (64'sd1 <<< (csgv_pkg::LEN_FRAC - FRAC)),
                                     len);
                    if (comp > two_r) comp = two_r;
                    if (comp < -two_r) comp = -two_r;
                end
                if (c == 0) v.px = comp[csgv_pkg::POS_W-1:0];
                else if (c == 1) v.py = comp[csgv_pkg::POS_W-1:0];
                else v.pz = comp[csgv_pkg::POS_W-1:0];
            end
            v.index = idx[csgv_pkg::INDEX_W-1:0];
            v.quad = (x < d) && (y < d);
            if (v.quad)
            begin
                v.corner[0] = csgv_pkg::INDEX_W'(idx + n);
                v.corner[1] = csgv_pkg::INDEX_W'(idx + n + 1);
                v.corner[2] = csgv_pkg::INDEX_W'(idx);
                v.corner[3] = csgv_pkg::INDEX_W'(idx + n + 1);
                v.corner[4] = csgv_pkg::INDEX_W'(idx + 1);
                v.corner[5] = csgv_pkg::INDEX_W'(idx);
            end
            else
                foreach (v.corner[k]) v.corner[k] = '0;
            return v;
        endfunction

        function void note_input(int gx, int gy);
            pending_q.push_back(predict_vertex(gx, gy));
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
            errors++;
        endtask

        task check_result(vertex_t got);
            vertex_t want;
            if (pending_q.size() == 0)
            begin
                report("unexpected result, index", got.index, -1);
                return;
            end
            want = pending_q.pop_front();
            checked++;
            if (got.index !== want.index) report("vertex_index", got.index, want.index);
            if (got.px !== want.px) report("pos_x", got.px, want.px);
            if (got.py !== want.py) report("pos_y", got.py, want.py);
            if (got.pz !== want.pz) report("pos_z", got.pz, want.pz);
            if (got.quad !== want.quad) report("has_quad", got.quad, want.quad);
            foreach (want.corner[k])
                if (got.corner[k] !== want.corner[k])
                    report($sformatf("tri_idx_%0d", k), got.corner[k], want.corner[k]);
        endtask
    endclass

    logic                                 clk;
    logic                                 rst_n;
    logic                                 start;
    logic                                 busy;
    logic [csgv_pkg::COORD_W-1:0]         grid_x;
    logic [csgv_pkg::COORD_W-1:0]         grid_y;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [csgv_pkg::CFG_IDX_W-1:0]       cfg_index;
    logic [csgv_pkg::CFG_DATA_W-1:0]      cfg_data;
    logic                                 done;
    logic [csgv_pkg::INDEX_W-1:0]         vertex_index;
    logic signed [csgv_pkg::POS_W-1:0]    pos_x;
    logic signed [csgv_pkg::POS_W-1:0]    pos_y;
    logic signed [csgv_pkg::POS_W-1:0]    pos_z;
    logic                                 has_quad;
    logic [csgv_pkg::INDEX_W-1:0]         tri_idx_0;
    logic [csgv_pkg::INDEX_W-1:0]         tri_idx_1;
    logic [csgv_pkg::INDEX_W-1:0]         tri_idx_2;
    logic [csgv_pkg::INDEX_W-1:0]         tri_idx_3;
    logic [csgv_pkg::INDEX_W-1:0]         tri_idx_4;
    logic [csgv_pkg::INDEX_W-1:0]         tri_idx_5;

    vertex_scoreboard sb;
    int burst_left;
    int sent;
    bit gaps_on;

    cube_sphere_grid_vertex dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .grid_x(grid_x), .grid_y(grid_y),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .vertex_index(vertex_index),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .has_quad(has_quad),
        .tri_idx_0(tri_idx_0), .tri_idx_1(tri_idx_1), .tri_idx_2(tri_idx_2),
        .tri_idx_3(tri_idx_3), .tri_idx_4(tri_idx_4), .tri_idx_5(tri_idx_5)
    );

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Results are sampled mid-cycle, well away from the edge that accepts them.
    always @(negedge clk)
    begin
        vertex_t got;
        if (rst_n && done)
        begin
            got.index = vertex_index;
            got.px = pos_x; got.py = pos_y; got.pz = pos_z;
            got.quad = has_quad;
            got.corner[0] = tri_idx_0; got.corner[1] = tri_idx_1;
            got.corner[2] = tri_idx_2; got.corner[3] = tri_idx_3;
            got.corner[4] = tri_idx_4; got.corner[5] = tri_idx_5;
            sb.check_result(got);
        end
    end

    initial
    begin
        #1000000;
        $display("TB_ERROR");
        $finish;
    end

    // Called at a rising edge; returns at the rising edge that completes the transfer.
    task send_vertex(int gx, int gy);
        if (gaps_on && burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        start <= 1'b1;
        grid_x <= csgv_pkg::COORD_W'(gx);
        grid_y <= csgv_pkg::COORD_W'(gy);
        @(negedge clk);
        while (busy) @(negedge clk);
        sb.note_input(gx, gy);
        sent++;
        if (burst_left > 0) burst_left--;
        @(posedge clk);
    endtask

    task write_reg(logic [csgv_pkg::CFG_IDX_W-1:0] idx,
                   logic [csgv_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        while (!cfg_ready) @(negedge clk);
        sb.set_reg(idx, data);
        @(posedge clk);
    endtask

    // Waits for the pipeline to drain, then applies a whole face setting.
    task set_face(int ux, int uy, int uz, int n, int r);
        start <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        write_reg(csgv_pkg::CFG_UP_X,
                  csgv_pkg::CFG_DATA_W'({$urandom} << 2) | csgv_pkg::CFG_DATA_W'(ux & 3));
        write_reg(csgv_pkg::CFG_UP_Y,
                  csgv_pkg::CFG_DATA_W'({$urandom} << 2) | csgv_pkg::CFG_DATA_W'(uy & 3));
        write_reg(csgv_pkg::CFG_UP_Z,
                  csgv_pkg::CFG_DATA_W'({$urandom} << 2) | csgv_pkg::CFG_DATA_W'(uz & 3));
        write_reg(csgv_pkg::CFG_GRID_SIZE, csgv_pkg::CFG_DATA_W'(n));
        write_reg(csgv_pkg::CFG_RADIUS, csgv_pkg::CFG_DATA_W'(r));
        // Writes to unused indexes must leave the face untouched.
        write_reg(CFG_UNUSED_5, csgv_pkg::CFG_DATA_W'($urandom));
        write_reg(CFG_UNUSED_7, csgv_pkg::CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task random_vertices(int count);
        int lim;
        lim = (sb.grid < 2) ? 1 : (sb.grid > GRID_MAX ? GRID_MAX - 1 : sb.grid - 1);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_vertex($urandom_range(0, 255), $urandom_range(0, 255));
            else
                send_vertex($urandom_range(0, lim), $urandom_range(0, lim));
        end
    endtask

    initial
    begin
        int ux;
        int uy;
        int uz;
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        grid_x = '0;
        grid_y = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        burst_left = 0;
        sent = 0;
        gaps_on = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset face: corners, center, last row and column, beyond the grid.
        send_vertex(0, 0);
        send_vertex(15, 15);
        send_vertex(14, 14);
        send_vertex(0, 15);
        send_vertex(15, 0);
        send_vertex(255, 255);
        send_vertex(200, 3);
        send_vertex(7, 8);
        send_vertex(8, 7);

        // Degenerate axis gives a zero-length point.
        set_face(0, 0, 0, 16, 30000);
        send_vertex(0, 0);
        send_vertex(8, 8);
        // Code for -2 saturates to -1; smallest grid and a radius of 1.
        set_face(2, 0, 0, 0, 1);
        send_vertex(0, 0);
        send_vertex(1, 1);
        send_vertex(255, 0);
        set_face(0, -1, 0, 1, 1048575);
        send_vertex(0, 1);
        send_vertex(1, 0);
        // Largest grid, and sizes above it that clamp.
        set_face(1, 1, 1, 256, 1048575);
        send_vertex(255, 255);
        send_vertex(254, 254);
        send_vertex(127, 128);
        set_face(-1, -1, -1, 511, 1048575);
        send_vertex(0, 255);
        send_vertex(254, 0);
        set_face(0, 0, -1, 257, 2);
        send_vertex(100, 254);

        for (int ph = 0; ph < 13; ph++)
        begin
            ux = $urandom_range(0, 3);
            uy = $urandom_range(0, 3);
            uz = $urandom_range(0, 3);
            case ($urandom_range(0, 3))
                0: set_face(ux, uy, uz, $urandom_range(2, 8), $urandom_range(1, 1048575));
                1: set_face(ux, uy, uz, $urandom_range(0, 511), $urandom_range(1, 1048575));
                2: set_face(ux, uy, uz, $urandom_range(9, 256), 1048575);
                default: set_face(ux, uy, uz, $urandom_range(2, 40), $urandom_range(1, 70000));
            endcase
            gaps_on = (ph % 3) != 0;
            random_vertices(65);
        end
        start <= 1'b0;

        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        $display("Sent %0d vertices over 20 face settings; %0d results compared.",
                 sent, sb.checked);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
